>>> rtl/bpfa_pkg.sv
// Shared constants, types and helper functions for the bitmap page frame allocator.
// No dependencies; the allocator top level imports this package.
`default_nettype none

package bpfa_pkg;

	localparam int unsigned TRACKED_PAGES = 1048576;
	localparam int unsigned PAGE_W        = 20;
	localparam int unsigned CNT_W         = 21;
	localparam int unsigned WORD_BITS     = 64;
	localparam int unsigned BIT_W         = $clog2(WORD_BITS);
	localparam int unsigned MAP_WORDS     = TRACKED_PAGES / WORD_BITS;
	localparam int unsigned ADDR_W        = $clog2(MAP_WORDS);
	localparam int unsigned SHIFT_W       = 5;

	localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(MAP_WORDS - 1);
	localparam logic [CNT_W-1:0]   PAGE_LIMIT = CNT_W'(TRACKED_PAGES);
	localparam logic [SHIFT_W-1:0] TOP_SHIFT = SHIFT_W'(CNT_W - 1);

	localparam logic [2:0] KIND_INIT    = 3'd0;
	localparam logic [2:0] KIND_ALLOC   = 3'd1;
	localparam logic [2:0] KIND_ALIGNED = 3'd2;
	localparam logic [2:0] KIND_FREE    = 3'd3;
	localparam logic [2:0] KIND_RESERVE = 3'd4;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT = 2'd1;
	localparam logic [1:0] STATUS_ZERO   = 2'd2;

	localparam logic [1:0] REG_RAM_BASE     = 2'd0;
	localparam logic [1:0] REG_RAM_COUNT    = 2'd1;
	localparam logic [1:0] REG_RESERVED_END = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_RNG_START,
		ST_RNG_RUN,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_ALIGN,
		ST_ALIGN_FIN,
		ST_DONE
	} state_t;

	function automatic logic [CNT_W-1:0] clip_page(input logic [CNT_W:0] v);
		clip_page = (v > {1'b0, PAGE_LIMIT}) ? PAGE_LIMIT : v[CNT_W-1:0];
	endfunction

	function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + {{BIT_W{1'b0}}, v[i]};
		end
		popcount = n;
	endfunction

	// Lowest set bit index, WORD_BITS when none is set
	function automatic logic [BIT_W:0] first_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] idx;
		idx = (BIT_W+1)'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = (BIT_W+1)'(i);
			end
		end
		first_set = idx;
	endfunction

	// Bits of word w whose page lies in [lo, e); needs e > lo
	function automatic logic [WORD_BITS-1:0] range_mask(input logic [ADDR_W-1:0] w,
			input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] e);
		logic [CNT_W-1:0]     last;
		logic [ADDR_W-1:0]    lw;
		logic [ADDR_W-1:0]    hw;
		logic [BIT_W-1:0]     lob;
		logic [BIT_W-1:0]     hib;
		logic [WORD_BITS-1:0] ones;
		last = e - CNT_W'(1);
		lw   = lo[BIT_W +: ADDR_W];
		hw   = last[BIT_W +: ADDR_W];
		lob  = (w == lw) ? lo[BIT_W-1:0] : '0;
		hib  = (w == hw) ? last[BIT_W-1:0] : '1;
		ones = '1;
		if (w < lw || w > hw) begin
			range_mask = '0;
		end else begin
			range_mask = (ones << lob) & (ones >> (BIT_W'(WORD_BITS - 1) - hib));
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator: one free bit per page in a 16384 x 64 map memory.
// Uses bpfa_pkg for constants, state type and bit-vector helpers.
//
// Usage: items arrive on in_valid/in_ready (kind, page, count, page_align);
// each gives one result on out_valid/out_ready (status, run_start,
// changed_pages, free_count, used_count). RAM range registers are to be
// written over the APB port only while the block is idle; the block does not
// enforce this. pready is always high. Items are handled one at a time.
// Free, reserve and the claim of an allocated run read and rewrite each map
// word touched. Init rewrites the whole map. First-fit scans in steps, a step
// ending at a used page or at a word boundary; an aligned search realigns at
// the start and past each used page. All of this is bound by the single read
// and single write port of the map. After reset the map memory is cleared
// word by word, during which in_ready is low; configuration writes are taken
// throughout. A finished result sits in the output register; the next item
// is accepted while it waits, and the block holds its next result until
// out_ready frees the slot.
`default_nettype none

module bitmap_page_frame_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  kind,
	input  wire logic [bpfa_pkg::PAGE_W-1:0] page,
	input  wire logic [bpfa_pkg::CNT_W-1:0]  count,
	input  wire logic [bpfa_pkg::CNT_W-1:0]  page_align,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [bpfa_pkg::PAGE_W-1:0]      run_start,
	output logic [bpfa_pkg::CNT_W-1:0]       changed_pages,
	output logic [bpfa_pkg::CNT_W-1:0]       free_count,
	output logic [bpfa_pkg::CNT_W-1:0]       used_count,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [3:0]                  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import bpfa_pkg::*;

	// map memory
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata_q;

	// configuration
	logic [PAGE_W-1:0] ram_base_q;
	logic [CNT_W-1:0]  ram_count_q;
	logic [CNT_W-1:0]  reserved_end_q;

	state_t state_q, state_d;
	logic [ADDR_W-1:0]  w_q, w_d;
	logic [2:0]         kind_q, kind_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [CNT_W-1:0]   al_q, al_d;
	logic [CNT_W-1:0]   lo_q, lo_d;
	logic [CNT_W-1:0]   e_q, e_d;
	logic               op_free_q, op_free_d;
	logic [CNT_W-1:0]   end_q, end_d;
	logic [CNT_W-1:0]   q_q, q_d;
	logic [CNT_W-1:0]   cand_q, cand_d;
	logic [CNT_W-1:0]   rl_q, rl_d;
	logic [CNT_W:0]     p_q, p_d;
	logic [CNT_W-1:0]   t_q, t_d;
	logic [SHIFT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0]   ft_q, ft_d;
	logic [CNT_W-1:0]   chg_q, chg_d;
	logic [1:0]         stat_q, stat_d;
	logic [PAGE_W-1:0]  start_q, start_d;
	logic               out_load;

	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [PAGE_W-1:0]    out_start_q;
	logic [CNT_W-1:0]     out_chg_q;
	logic [CNT_W-1:0]     out_free_q;
	logic [CNT_W-1:0]     out_used_q;

	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_RAM_BASE:     prdata = {{(32-PAGE_W){1'b0}}, ram_base_q};
			REG_RAM_COUNT:    prdata = {{(32-CNT_W){1'b0}}, ram_count_q};
			REG_RESERVED_END: prdata = {{(32-CNT_W){1'b0}}, reserved_end_q};
			default:          prdata = '0;
		endcase
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign run_start     = out_start_q;
	assign changed_pages = out_chg_q;
	assign free_count    = out_free_q;
	assign used_count    = out_used_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= map_mem[mem_raddr];
		end
	end

	// scan helpers
	logic [BIT_W-1:0]     qbit;
	logic [PAGE_W-1:0]    wbase;
	logic [CNT_W-1:0]     end_m1;
	logic [BIT_W-1:0]     lim;
	logic [WORD_BITS-1:0] ones;
	logic [WORD_BITS-1:0] used_m;
	logic [BIT_W:0]       u_idx;
	logic [BIT_W:0]       stop;
	logic [BIT_W:0]       run_f;
	logic [CNT_W:0]       run_sum;
	logic [CNT_W-1:0]     next_q;
	logic [CNT_W-1:0]     past_q;

	// range helpers
	logic [WORD_BITS-1:0] rmask;
	logic [WORD_BITS-1:0] hit;
	logic [BIT_W:0]       hit_n;
	logic [CNT_W-1:0]     e_m1;

	// align helpers
	logic [2*CNT_W-1:0]   step;
	logic [2*CNT_W:0]     step_sum;
	logic [CNT_W+1:0]     p_fin;

	// dispatch helpers
	logic [CNT_W-1:0] ilo;
	logic [CNT_W-1:0] iend;
	logic [CNT_W-1:0] rsv_clip;
	logic [CNT_W-1:0] rng_e;

	assign ones     = '1;
	assign qbit     = q_q[BIT_W-1:0];
	assign wbase    = {q_q[BIT_W +: ADDR_W], {BIT_W{1'b0}}};
	assign end_m1   = end_q - CNT_W'(1);
	assign lim      = (end_m1[BIT_W +: ADDR_W] == q_q[BIT_W +: ADDR_W]) ?
	                  end_m1[BIT_W-1:0] : '1;
	assign used_m   = ~mem_rdata_q & (ones << qbit) & (ones >> (BIT_W'(WORD_BITS - 1) - lim));
	assign u_idx    = first_set(used_m);
	assign stop     = (used_m == '0) ? ({1'b0, lim} + (BIT_W+1)'(1)) : u_idx;
	assign run_f    = stop - {1'b0, qbit};
	assign run_sum  = {1'b0, rl_q} + (CNT_W+1)'(run_f);
	assign next_q   = {1'b0, wbase} + CNT_W'(u_idx) + CNT_W'(1);
	assign past_q   = {1'b0, wbase} + CNT_W'(lim) + CNT_W'(1);

	assign rmask    = range_mask(w_q, lo_q, e_q);
	assign hit      = op_free_q ? (rmask & ~mem_rdata_q) : (rmask & mem_rdata_q);
	assign hit_n    = popcount(hit);
	assign e_m1     = e_q - CNT_W'(1);

	assign step     = (2*CNT_W)'(al_q) << k_q;
	assign step_sum = (2*CNT_W+1)'(p_q) + (2*CNT_W+1)'(step);
	assign p_fin    = (p_q < {1'b0, t_q}) ? ((CNT_W+2)'(p_q) + (CNT_W+2)'(al_q))
	                                      : (CNT_W+2)'(p_q);

	assign rsv_clip = clip_page({1'b0, reserved_end_q});
	assign ilo      = (rsv_clip > CNT_W'(ram_base_q)) ? rsv_clip : CNT_W'(ram_base_q);
	assign iend     = clip_page((CNT_W+1)'(ram_base_q) + (CNT_W+1)'(ram_count_q));
	assign rng_e    = clip_page((CNT_W+1)'(page) + (CNT_W+1)'(count));

	always_comb begin
		state_d   = state_q;
		w_d       = w_q;
		kind_d    = kind_q;
		cnt_d     = cnt_q;
		al_d      = al_q;
		lo_d      = lo_q;
		e_d       = e_q;
		op_free_d = op_free_q;
		end_d     = end_q;
		q_d       = q_q;
		cand_d    = cand_q;
		rl_d      = rl_q;
		p_d       = p_q;
		t_d       = t_q;
		k_d       = k_q;
		ft_d      = ft_q;
		chg_d     = chg_q;
		stat_d    = stat_q;
		start_d   = start_q;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = w_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = w_q;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (w_q == LAST_WORD) begin
					w_d     = '0;
					state_d = ST_IDLE;
				end else begin
					w_d = w_q + ADDR_W'(1);
				end
			end

			ST_IDLE: begin
				if (in_valid) begin
					kind_d  = kind;
					cnt_d   = count;
					al_d    = (page_align == '0) ? CNT_W'(1) : page_align;
					end_d   = iend;
					stat_d  = STATUS_OK;
					start_d = '0;
					chg_d   = '0;
					case (kind)
						KIND_INIT: begin
							lo_d    = ilo;
							e_d     = iend;
							w_d     = '0;
							state_d = ST_INIT;
						end
						KIND_ALLOC, KIND_ALIGNED: begin
							if (count == '0) begin
								stat_d  = STATUS_ZERO;
								state_d = ST_DONE;
							end else if (ft_q < count) begin
								stat_d  = STATUS_NO_FIT;
								state_d = ST_DONE;
							end else if (kind == KIND_ALLOC) begin
								q_d     = CNT_W'(ram_base_q);
								cand_d  = CNT_W'(ram_base_q);
								rl_d    = '0;
								state_d = ST_SCAN_RD;
							end else begin
								p_d     = '0;
								t_d     = CNT_W'(ram_base_q);
								k_d     = TOP_SHIFT;
								state_d = ST_ALIGN;
							end
						end
						KIND_FREE, KIND_RESERVE: begin
							lo_d      = CNT_W'(page);
							e_d       = rng_e;
							op_free_d = (kind == KIND_FREE);
							state_d   = (rng_e > CNT_W'(page)) ? ST_RNG_START : ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = (e_q > lo_q) ? range_mask(w_q, lo_q, e_q) : '0;
				if (w_q == LAST_WORD) begin
					ft_d    = (e_q > lo_q) ? (e_q - lo_q) : '0;
					chg_d   = (e_q > lo_q) ? (e_q - lo_q) : '0;
					w_d     = '0;
					state_d = ST_DONE;
				end else begin
					w_d = w_q + ADDR_W'(1);
				end
			end

			ST_RNG_START: begin
				mem_re    = 1'b1;
				mem_raddr = lo_q[BIT_W +: ADDR_W];
				w_d       = lo_q[BIT_W +: ADDR_W];
				state_d   = ST_RNG_RUN;
			end

			ST_RNG_RUN: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = op_free_q ? (mem_rdata_q | rmask) : (mem_rdata_q & ~rmask);
				chg_d     = chg_q + CNT_W'(hit_n);
				ft_d      = op_free_q ? (ft_q + CNT_W'(hit_n)) : (ft_q - CNT_W'(hit_n));
				if (w_q == e_m1[BIT_W +: ADDR_W]) begin
					state_d = ST_DONE;
				end else begin
					// overlap the next read with this write; different words
					mem_re    = 1'b1;
					mem_raddr = w_q + ADDR_W'(1);
					w_d       = w_q + ADDR_W'(1);
				end
			end

			ST_SCAN_RD: begin
				if (q_q >= end_q) begin
					stat_d  = STATUS_NO_FIT;
					state_d = ST_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = q_q[BIT_W +: ADDR_W];
					state_d   = ST_SCAN_EV;
				end
			end

			ST_SCAN_EV: begin
				if (run_sum >= {1'b0, cnt_q}) begin
					// run complete: claim it through the range engine
					start_d   = cand_q[PAGE_W-1:0];
					lo_d      = cand_q;
					e_d       = clip_page((CNT_W+1)'(cand_q) + (CNT_W+1)'(cnt_q));
					op_free_d = 1'b0;
					state_d   = ST_RNG_START;
				end else if (used_m != '0) begin
					if (kind_q == KIND_ALLOC) begin
						q_d     = next_q;
						cand_d  = next_q;
						rl_d    = '0;
						state_d = ST_SCAN_RD;
					end else begin
						p_d     = (CNT_W+1)'(cand_q);
						t_d     = next_q;
						k_d     = TOP_SHIFT;
						state_d = ST_ALIGN;
					end
				end else begin
					rl_d    = run_sum[CNT_W-1:0];
					q_d     = past_q;
					state_d = ST_SCAN_RD;
				end
			end

			// advance p to the last multiple step below t, largest stride first
			ST_ALIGN: begin
				if (step_sum < (2*CNT_W+1)'(t_q)) begin
					p_d = step_sum[CNT_W:0];
				end
				if (k_q == '0) begin
					state_d = ST_ALIGN_FIN;
				end else begin
					k_d = k_q - SHIFT_W'(1);
				end
			end

			ST_ALIGN_FIN: begin
				if ((CNT_W+2)'(p_fin) + (CNT_W+2)'(cnt_q) > (CNT_W+2)'(end_q)) begin
					stat_d  = STATUS_NO_FIT;
					state_d = ST_DONE;
				end else begin
					q_d     = p_fin[CNT_W-1:0];
					cand_d  = p_fin[CNT_W-1:0];
					rl_d    = '0;
					state_d = ST_SCAN_RD;
				end
			end

			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q            <= '0;
			ft_q           <= '0;
			ram_base_q     <= '0;
			ram_count_q    <= '0;
			reserved_end_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			w_q  <= w_d;
			ft_q <= ft_d;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_RAM_BASE:     ram_base_q     <= pwdata[PAGE_W-1:0];
					REG_RAM_COUNT:    ram_count_q    <= pwdata[CNT_W-1:0];
					REG_RESERVED_END: reserved_end_q <= pwdata[CNT_W-1:0];
					default:          ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		cnt_q     <= cnt_d;
		al_q      <= al_d;
		lo_q      <= lo_d;
		e_q       <= e_d;
		op_free_q <= op_free_d;
		end_q     <= end_d;
		q_q       <= q_d;
		cand_q    <= cand_d;
		rl_q      <= rl_d;
		p_q       <= p_d;
		t_q       <= t_d;
		k_q       <= k_d;
		chg_q     <= chg_d;
		stat_q    <= stat_d;
		start_q   <= start_d;
		if (out_load) begin
			out_status_q <= stat_q;
			out_start_q  <= start_q;
			out_chg_q    <= chg_q;
			out_free_q   <= ft_q;
			out_used_q   <= (ram_count_q > ft_q) ? (ram_count_q - ft_q) : '0;
		end
	end

endmodule

`default_nettype wire
